>>> rtl/core/chc_pkg.sv
// shared types, widths and constants of the cubic hermite curve evaluator
`timescale 1ns / 1ps

package chc_pkg;

  // table shape and parameter format
  localparam int MAX_PIECES = 16;
  localparam int FRAC_BITS  = 16;
  localparam int KNOTS      = MAX_PIECES + 1;
  localparam int KNOT_AW    = $clog2(KNOTS);

  // field widths
  localparam int IDX_W    = 5;
  localparam int PIECES_W = 5;
  localparam int PARAM_W  = 21;
  localparam int COORD_W  = 32;

  // arithmetic widths
  localparam int S_W    = FRAC_BITS + 1;        // s in [0, 1.0]
  localparam int SQP_W  = 2 * S_W;              // s*s plus rounding
  localparam int WT_W   = S_W + 2;              // basis weights, signed
  localparam int PROD_W = COORD_W + WT_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SHR_W  = ACC_W - FRAC_BITS;

  // pipeline stages, one register each
  localparam int STG_RD   = 0;  // knot rows read, segment fraction
  localparam int STG_SQ   = 1;  // s^2
  localparam int STG_CU   = 2;  // s^3
  localparam int STG_WT   = 3;  // basis weights
  localparam int STG_MUL  = 4;  // coordinate times weight
  localparam int STG_PAIR = 5;  // pairwise sums
  localparam int STG_RND  = 6;  // final sum, round, scale
  localparam int STG_OUT  = 7;  // saturate, output register
  localparam int NUM_STG  = 8;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_PIECES = 1'b0;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef logic [NUM_STG-1:0] stage_vec_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WT_W-1:0] wt_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t vel_x;
    coord_t vel_y;
    coord_t vel_z;
  } knot_row_t;

  typedef struct packed {
    wt_t h00;
    wt_t h10;
    wt_t h01;
    wt_t h11;
  } weights_t;

  localparam logic [S_W-1:0]   ONE_S   = S_W'(1) << FRAC_BITS;
  localparam logic [SQP_W-1:0] HALF_SQ = SQP_W'(1) << (FRAC_BITS - 1);
  localparam wt_t              ONE_WT  = WT_W'(ONE_S);
  localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (FRAC_BITS - 1);
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic prod_t coord_ext(coord_t v);
    return PROD_W'(v);
  endfunction

  function automatic prod_t wt_ext(wt_t v);
    return PROD_W'(v);
  endfunction

endpackage

>>> rtl/core/chc_knot_store.sv
// knot table: one row per knot, written by write items, read twice per evaluation
`timescale 1ns / 1ps

module chc_knot_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clr,
  input  logic                              wr_en,
  input  logic [chc_pkg::IDX_W-1:0]         wr_idx,
  input  chc_pkg::knot_row_t                wr_row,
  input  logic                              rd_en,
  input  logic [chc_pkg::KNOT_AW-1:0]       rd_addr_a,
  input  logic [chc_pkg::KNOT_AW-1:0]       rd_addr_b,
  output chc_pkg::knot_row_t                rd_a,
  output chc_pkg::knot_row_t                rd_b
);

  chc_pkg::knot_row_t mem [chc_pkg::KNOTS];
  logic [chc_pkg::KNOTS-1:0]   row_v_r;
  chc_pkg::knot_row_t          rd_a_r;
  chc_pkg::knot_row_t          rd_b_r;
  logic                        va_r;
  logic                        vb_r;
  logic                        wr_ok;
  logic [chc_pkg::KNOT_AW-1:0] wr_addr;

  // writes beyond the last knot are dropped
  assign wr_ok   = wr_en && (wr_idx <= chc_pkg::IDX_W'(chc_pkg::MAX_PIECES));
  assign wr_addr = chc_pkg::KNOT_AW'(wr_idx);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
      va_r   <= row_v_r[rd_addr_a];
      vb_r   <= row_v_r[rd_addr_b];
    end
  end

  // a row never written since reset or the last reshape reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_v_r <= '0;
    end else if (clr) begin
      row_v_r <= '0;
    end else if (wr_ok) begin
      row_v_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_a = va_r ? rd_a_r : '0;
  assign rd_b = vb_r ? rd_b_r : '0;

  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (row_v_r == '0))
    else $error("knot table not cleared after reshape");

  a_wr_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ok && !clr) |=> row_v_r[$past(wr_addr)])
    else $error("written knot row not marked valid");

endmodule

>>> rtl/core/chc_weights.sv
// hermite basis weights from the segment fraction: s^2, s^3, then the four blends
`timescale 1ns / 1ps

module chc_weights (
  input  logic                        clk,
  input  chc_pkg::stage_vec_t         adv,
  input  logic [chc_pkg::S_W-1:0]     s_in,
  output chc_pkg::weights_t           wt
);

  logic [chc_pkg::S_W-1:0]   s1_r;
  logic [chc_pkg::S_W-1:0]   s2_r;
  logic [chc_pkg::S_W-1:0]   sq_r;
  logic [chc_pkg::S_W-1:0]   sq2_r;
  logic [chc_pkg::S_W-1:0]   cu_r;
  logic [chc_pkg::SQP_W-1:0] sq_full;
  logic [chc_pkg::SQP_W-1:0] cu_full;
  chc_pkg::wt_t              s_e;
  chc_pkg::wt_t              sq_e;
  chc_pkg::wt_t              cu_e;
  chc_pkg::weights_t         wt_nxt;
  chc_pkg::weights_t         wt_r;

  // round half up back to FRAC_BITS fraction bits
  assign sq_full = chc_pkg::SQP_W'(s_in) * chc_pkg::SQP_W'(s_in) + chc_pkg::HALF_SQ;
  assign cu_full = chc_pkg::SQP_W'(sq_r) * chc_pkg::SQP_W'(s1_r) + chc_pkg::HALF_SQ;

  always_ff @(posedge clk) begin
    if (adv[chc_pkg::STG_SQ]) begin
      sq_r <= sq_full[chc_pkg::FRAC_BITS +: chc_pkg::S_W];
      s1_r <= s_in;
    end
    if (adv[chc_pkg::STG_CU]) begin
      cu_r  <= cu_full[chc_pkg::FRAC_BITS +: chc_pkg::S_W];
      sq2_r <= sq_r;
      s2_r  <= s1_r;
    end
    if (adv[chc_pkg::STG_WT]) begin
      wt_r <= wt_nxt;
    end
  end

  always_comb begin
    s_e  = chc_pkg::WT_W'(s2_r);
    sq_e = chc_pkg::WT_W'(sq2_r);
    cu_e = chc_pkg::WT_W'(cu_r);
    wt_nxt.h00 = (cu_e <<< 1) - (sq_e <<< 1) - sq_e + chc_pkg::ONE_WT;
    wt_nxt.h10 = cu_e - (sq_e <<< 1) + s_e;
    wt_nxt.h01 = (sq_e <<< 1) + sq_e - (cu_e <<< 1);
    wt_nxt.h11 = cu_e - sq_e;
  end

  assign wt = wt_r;

endmodule

>>> rtl/core/chc_blend.sv
// per-coordinate blend of two knots with the basis weights, rounding and saturation
`timescale 1ns / 1ps

module chc_blend (
  input  logic                  clk,
  input  chc_pkg::stage_vec_t   adv,
  input  chc_pkg::knot_row_t    row_a,
  input  chc_pkg::knot_row_t    row_b,
  input  chc_pkg::weights_t     wt,
  output chc_pkg::coord_t       point_x,
  output chc_pkg::coord_t       point_y,
  output chc_pkg::coord_t       point_z
);

  // knot rows wait here while the weights are built
  chc_pkg::knot_row_t a_d1_r, a_d2_r, a_d3_r;
  chc_pkg::knot_row_t b_d1_r, b_d2_r, b_d3_r;

  chc_pkg::coord_t pa [3];
  chc_pkg::coord_t va [3];
  chc_pkg::coord_t pb [3];
  chc_pkg::coord_t vb [3];

  chc_pkg::prod_t                     prod_r [3][4];
  logic signed [chc_pkg::ACC_W-1:0]   pair_r [3][2];
  logic signed [chc_pkg::ACC_W-1:0]   acc    [3];
  logic signed [chc_pkg::SHR_W-1:0]   shr_r  [3];
  logic [chc_pkg::SHR_W-chc_pkg::COORD_W:0] top_bits [3];
  chc_pkg::coord_t                    sat_nxt [3];
  chc_pkg::coord_t                    out_r   [3];

  always_ff @(posedge clk) begin
    if (adv[chc_pkg::STG_SQ]) begin
      a_d1_r <= row_a;
      b_d1_r <= row_b;
    end
    if (adv[chc_pkg::STG_CU]) begin
      a_d2_r <= a_d1_r;
      b_d2_r <= b_d1_r;
    end
    if (adv[chc_pkg::STG_WT]) begin
      a_d3_r <= a_d2_r;
      b_d3_r <= b_d2_r;
    end
  end

  always_comb begin
    pa[0] = a_d3_r.pos_x;  pa[1] = a_d3_r.pos_y;  pa[2] = a_d3_r.pos_z;
    va[0] = a_d3_r.vel_x;  va[1] = a_d3_r.vel_y;  va[2] = a_d3_r.vel_z;
    pb[0] = b_d3_r.pos_x;  pb[1] = b_d3_r.pos_y;  pb[2] = b_d3_r.pos_z;
    vb[0] = b_d3_r.vel_x;  vb[1] = b_d3_r.vel_y;  vb[2] = b_d3_r.vel_z;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = pair_r[c][0] + pair_r[c][1] + chc_pkg::HALF_ACC;
      top_bits[c] = shr_r[c][chc_pkg::SHR_W-1:chc_pkg::COORD_W-1];
      // fits when all bits above the sign agree with it
      if ((&top_bits[c]) || !(|top_bits[c])) begin
        sat_nxt[c] = shr_r[c][chc_pkg::COORD_W-1:0];
      end else if (shr_r[c][chc_pkg::SHR_W-1]) begin
        sat_nxt[c] = chc_pkg::COORD_MIN;
      end else begin
        sat_nxt[c] = chc_pkg::COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (adv[chc_pkg::STG_MUL]) begin
        prod_r[c][0] <= chc_pkg::coord_ext(pa[c]) * chc_pkg::wt_ext(wt.h00);
        prod_r[c][1] <= chc_pkg::coord_ext(va[c]) * chc_pkg::wt_ext(wt.h10);
        prod_r[c][2] <= chc_pkg::coord_ext(pb[c]) * chc_pkg::wt_ext(wt.h01);
        prod_r[c][3] <= chc_pkg::coord_ext(vb[c]) * chc_pkg::wt_ext(wt.h11);
      end
      if (adv[chc_pkg::STG_PAIR]) begin
        pair_r[c][0] <= chc_pkg::ACC_W'(prod_r[c][0]) + chc_pkg::ACC_W'(prod_r[c][1]);
        pair_r[c][1] <= chc_pkg::ACC_W'(prod_r[c][2]) + chc_pkg::ACC_W'(prod_r[c][3]);
      end
      if (adv[chc_pkg::STG_RND]) begin
        // floor after adding a half: round half toward +inf
        shr_r[c] <= acc[c][chc_pkg::ACC_W-1:chc_pkg::FRAC_BITS];
      end
      if (adv[chc_pkg::STG_OUT]) begin
        out_r[c] <= sat_nxt[c];
      end
    end
  end

  assign point_x = out_r[0];
  assign point_y = out_r[1];
  assign point_z = out_r[2];

endmodule

>>> rtl/core/cubic_hermite_curve_eval.sv
// top level: piecewise cubic hermite 3d curve evaluator with knot table and apb register
//
// usage
//   input channel (in_*): each transfer is a write (stores knot in_knot_index,
//   position and velocity) or an evaluate (in_eval_param, unsigned Q5.16).
//   writes give no result; every evaluate gives one point on out_* in order.
//   apb port (cfg_*): register 0 at byte address 0 is pieces_in_use; a write
//   also clears the whole knot table. write it only while no item is in flight.
//   pready is tied high.
//   pipeline: eight register stages (row read, s^2, s^3, weights, products,
//   pair sums, round, saturate); out_* comes from the saturate register.
//   throughput: one item per cycle, sustained while out_stall is low; the
//   knot table has one write port and two read ports, read in the same
//   cycle the evaluate is taken.
//   reset: knot table reads as zero, pieces_in_use is 1, pipeline empty.
//   stall: each stage holds only while the stage after it is full and held,
//   so bubbles close up; in_stall rises only when all eight stages are full
//   and out_stall is high.
`timescale 1ns / 1ps

module cubic_hermite_curve_eval (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [chc_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [chc_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [chc_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [chc_pkg::IDX_W-1:0]         in_knot_index,
  input  logic signed [chc_pkg::COORD_W-1:0] in_knot_pos_x,
  input  logic signed [chc_pkg::COORD_W-1:0] in_knot_pos_y,
  input  logic signed [chc_pkg::COORD_W-1:0] in_knot_pos_z,
  input  logic signed [chc_pkg::COORD_W-1:0] in_knot_vel_x,
  input  logic signed [chc_pkg::COORD_W-1:0] in_knot_vel_y,
  input  logic signed [chc_pkg::COORD_W-1:0] in_knot_vel_z,
  input  logic [chc_pkg::PARAM_W-1:0]       in_eval_param,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [chc_pkg::COORD_W-1:0] out_point_x,
  output logic signed [chc_pkg::COORD_W-1:0] out_point_y,
  output logic signed [chc_pkg::COORD_W-1:0] out_point_z,
  output logic                              out_param_clamped
);

  logic [chc_pkg::PIECES_W-1:0] pieces_r;
  logic [chc_pkg::PIECES_W-1:0] eff_pieces_r;
  logic [chc_pkg::PIECES_W-1:0] eff_pieces_nxt;
  logic [chc_pkg::PIECES_W-1:0] wdata_pieces;
  logic                         cfg_wr;

  chc_pkg::stage_vec_t adv;
  chc_pkg::stage_vec_t v_r;
  chc_pkg::stage_vec_t clamp_r;
  chc_pkg::stage_vec_t v_shift;
  chc_pkg::stage_vec_t clamp_shift;

  logic                          take_eval;
  logic                          take_write;
  logic [chc_pkg::PARAM_W-1:0]   limit;
  logic                          clamp_in;
  logic [chc_pkg::PARAM_W-1:0]   t_sat;
  logic [chc_pkg::PIECES_W-1:0]  seg_raw;
  logic                          at_end;
  logic [chc_pkg::PIECES_W-1:0]  seg;
  logic [chc_pkg::PIECES_W-1:0]  seg_next;
  logic [chc_pkg::S_W-1:0]       s_in;
  logic [chc_pkg::S_W-1:0]       s_r;

  chc_pkg::knot_row_t wr_row;
  chc_pkg::knot_row_t row_a;
  chc_pkg::knot_row_t row_b;
  chc_pkg::weights_t  wt;

  // ---------------- configuration ----------------
  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                        (cfg_paddr[2] == chc_pkg::REG_PIECES);
  assign wdata_pieces = cfg_pwdata[chc_pkg::PIECES_W-1:0];

  always_comb begin
    priority if (wdata_pieces == '0) begin
      eff_pieces_nxt = chc_pkg::PIECES_W'(1);
    end else if (wdata_pieces > chc_pkg::PIECES_W'(chc_pkg::MAX_PIECES)) begin
      eff_pieces_nxt = chc_pkg::PIECES_W'(chc_pkg::MAX_PIECES);
    end else begin
      eff_pieces_nxt = wdata_pieces;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pieces_r     <= chc_pkg::PIECES_W'(1);
      eff_pieces_r <= chc_pkg::PIECES_W'(1);
    end else if (cfg_wr) begin
      pieces_r     <= wdata_pieces;
      eff_pieces_r <= eff_pieces_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == chc_pkg::REG_PIECES) ?
                      chc_pkg::CFG_DW'(pieces_r) : '0;

  // ---------------- pipeline flow ----------------
  always_comb begin
    adv[chc_pkg::NUM_STG-1] = !v_r[chc_pkg::NUM_STG-1] || !out_stall;
    for (int k = chc_pkg::NUM_STG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall   = !adv[chc_pkg::STG_RD];
  assign take_eval  = in_valid && (in_command == chc_pkg::CMD_EVAL);
  assign take_write = in_valid && !in_stall && (in_command == chc_pkg::CMD_WRITE);

  // ---------------- segment select ----------------
  always_comb begin
    limit    = chc_pkg::PARAM_W'(eff_pieces_r) << chc_pkg::FRAC_BITS;
    clamp_in = in_eval_param > limit;
    t_sat    = clamp_in ? limit : in_eval_param;
    seg_raw  = t_sat[chc_pkg::PARAM_W-1:chc_pkg::FRAC_BITS];
    // t at the last knot: last segment with s = 1
    at_end   = seg_raw >= eff_pieces_r;
    seg      = at_end ? (eff_pieces_r - chc_pkg::PIECES_W'(1)) : seg_raw;
    seg_next = seg + chc_pkg::PIECES_W'(1);
    s_in     = at_end ? chc_pkg::ONE_S : {1'b0, t_sat[chc_pkg::FRAC_BITS-1:0]};
  end

  assign v_shift     = {v_r[chc_pkg::NUM_STG-2:0], take_eval};
  assign clamp_shift = {clamp_r[chc_pkg::NUM_STG-2:0], clamp_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < chc_pkg::NUM_STG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_shift[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < chc_pkg::NUM_STG; k++) begin
      if (adv[k]) begin
        clamp_r[k] <= clamp_shift[k];
      end
    end
    if (adv[chc_pkg::STG_RD]) begin
      s_r <= s_in;
    end
  end

  // ---------------- datapath ----------------
  always_comb begin
    wr_row.pos_x = in_knot_pos_x;
    wr_row.pos_y = in_knot_pos_y;
    wr_row.pos_z = in_knot_pos_z;
    wr_row.vel_x = in_knot_vel_x;
    wr_row.vel_y = in_knot_vel_y;
    wr_row.vel_z = in_knot_vel_z;
  end

  chc_knot_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_wr),
    .wr_en     (take_write),
    .wr_idx    (in_knot_index),
    .wr_row    (wr_row),
    .rd_en     (adv[chc_pkg::STG_RD]),
    .rd_addr_a (chc_pkg::KNOT_AW'(seg)),
    .rd_addr_b (chc_pkg::KNOT_AW'(seg_next)),
    .rd_a      (row_a),
    .rd_b      (row_b)
  );

  chc_weights u_weights (
    .clk  (clk),
    .adv  (adv),
    .s_in (s_r),
    .wt   (wt)
  );

  chc_blend u_blend (
    .clk     (clk),
    .adv     (adv),
    .row_a   (row_a),
    .row_b   (row_b),
    .wt      (wt),
    .point_x (out_point_x),
    .point_y (out_point_y),
    .point_z (out_point_z)
  );

  assign out_valid         = v_r[chc_pkg::STG_OUT];
  assign out_param_clamped = clamp_r[chc_pkg::STG_OUT];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_stall))
    else $error("input held off while the pipeline has room");

  a_eval_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_command == chc_pkg::CMD_EVAL)) |=> v_r[chc_pkg::STG_RD])
    else $error("accepted evaluate missing from the first stage");

  a_write_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_command == chc_pkg::CMD_WRITE)) |=> !v_r[chc_pkg::STG_RD])
    else $error("knot write took a result slot");

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the cubic hermite curve evaluator, with its own point predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 5;
  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 12;
  localparam longint CYCLE_LIMIT = 800000;

  // local names for the shared widths and limits
  localparam int MAX_PIECES = chc_pkg::MAX_PIECES;
  localparam int FRAC_BITS  = chc_pkg::FRAC_BITS;
  localparam int KNOTS      = chc_pkg::KNOTS;
  localparam int IDX_W      = chc_pkg::IDX_W;
  localparam int PIECES_W   = chc_pkg::PIECES_W;
  localparam int PARAM_W    = chc_pkg::PARAM_W;
  localparam int CFG_AW     = chc_pkg::CFG_AW;
  localparam int CFG_DW     = chc_pkg::CFG_DW;
  localparam chc_pkg::coord_t COORD_MAX = chc_pkg::COORD_MAX;
  localparam chc_pkg::coord_t COORD_MIN = chc_pkg::COORD_MIN;

  localparam int REG_PIECES_I = int'(chc_pkg::REG_PIECES);
  localparam int REG_SPARE    = 1;

  localparam longint ONE_FIX  = longint'(1) << FRAC_BITS;
  localparam longint HALF_FIX = longint'(1) << (FRAC_BITS - 1);
  localparam chc_pkg::coord_t ONE_Q   = 32'sh0001_0000;
  localparam chc_pkg::coord_t MINUS_1 = -32'sd1;

  typedef struct {
    chc_pkg::coord_t x;
    chc_pkg::coord_t y;
    chc_pkg::coord_t z;
    logic            clamped;
  } curve_point_t;

  typedef struct {
    chc_pkg::cmd_t      cmd;
    logic [IDX_W-1:0]   idx;
    chc_pkg::coord_t    pos[3];
    chc_pkg::coord_t    vel[3];
    logic [PARAM_W-1:0] t;
    bit                 known;
    curve_point_t       want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  logic                in_valid;
  logic                in_stall;
  logic                in_command;
  logic [IDX_W-1:0]    in_knot_index;
  chc_pkg::coord_t     in_knot_pos_x;
  chc_pkg::coord_t     in_knot_pos_y;
  chc_pkg::coord_t     in_knot_pos_z;
  chc_pkg::coord_t     in_knot_vel_x;
  chc_pkg::coord_t     in_knot_vel_y;
  chc_pkg::coord_t     in_knot_vel_z;
  logic [PARAM_W-1:0]  in_eval_param;

  logic                out_valid;
  logic                out_stall;
  chc_pkg::coord_t     out_point_x;
  chc_pkg::coord_t     out_point_y;
  chc_pkg::coord_t     out_point_z;
  logic                out_param_clamped;

  // predictor state
  logic [PIECES_W-1:0] pieces_reg;
  chc_pkg::coord_t     knot_pos_tbl[KNOTS][3];
  chc_pkg::coord_t     knot_vel_tbl[KNOTS][3];
  curve_point_t        pending_points[$];

  int     fail_count;
  longint cycle_count;
  bit     send_quiet;
  bit     recv_quiet;
  int     holds_requested;
  int     holds_served;

  cubic_hermite_curve_eval dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_knot_index     (in_knot_index),
    .in_knot_pos_x     (in_knot_pos_x),
    .in_knot_pos_y     (in_knot_pos_y),
    .in_knot_pos_z     (in_knot_pos_z),
    .in_knot_vel_x     (in_knot_vel_x),
    .in_knot_vel_y     (in_knot_vel_y),
    .in_knot_vel_z     (in_knot_vel_z),
    .in_eval_param     (in_eval_param),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_point_z       (out_point_z),
    .out_param_clamped (out_param_clamped)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int eff_pieces();
    int p;
    p = int'(pieces_reg);
    if (p < 1) p = 1;
    if (p > MAX_PIECES) p = MAX_PIECES;
    return p;
  endfunction

  function automatic void clear_knots();
    foreach (knot_pos_tbl[k, c]) begin
      knot_pos_tbl[k][c] = '0;
      knot_vel_tbl[k][c] = '0;
    end
  endfunction

  // blended point for parameter t against the current knot table
  function automatic curve_point_t hermite_point(logic [PARAM_W-1:0] t_in);
    curve_point_t pt;
    chc_pkg::coord_t res[3];
    longint p, t, seg, s, s2, s3, h00, h10, h01, h11, acc;
    p = eff_pieces();
    t = longint'(t_in);
    pt.clamped = 1'b0;
    if (t > (p << FRAC_BITS)) begin
      t = p << FRAC_BITS;
      pt.clamped = 1'b1;
    end
    seg = t >>> FRAC_BITS;
    // t exactly at the end uses the last segment at s = 1
    if (seg >= p) seg = p - 1;
    s   = t - (seg << FRAC_BITS);
    s2  = (s * s + HALF_FIX) >>> FRAC_BITS;
    s3  = (s2 * s + HALF_FIX) >>> FRAC_BITS;
    h00 = 2 * s3 - 3 * s2 + ONE_FIX;
    h10 = s3 - 2 * s2 + s;
    h01 = -2 * s3 + 3 * s2;
    h11 = s3 - s2;
    for (int c = 0; c < 3; c++) begin
      acc = longint'(knot_pos_tbl[seg][c]) * h00
          + longint'(knot_vel_tbl[seg][c]) * h10
          + longint'(knot_pos_tbl[seg + 1][c]) * h01
          + longint'(knot_vel_tbl[seg + 1][c]) * h11;
      acc = (acc + HALF_FIX) >>> FRAC_BITS;
      if (acc > 64'sd2147483647) res[c] = COORD_MAX;
      else if (acc < -64'sd2147483648) res[c] = COORD_MIN;
      else res[c] = chc_pkg::coord_t'(acc);
    end
    pt.x = res[0];
    pt.y = res[1];
    pt.z = res[2];
    return pt;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic chc_pkg::coord_t rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return COORD_MAX;
        1: return COORD_MIN;
        2: return '0;
        default: return MINUS_1;
      endcase
    end
    if (r < 25) return chc_pkg::coord_t'($urandom);
    // mostly moderate coordinates, about +-32.0
    return chc_pkg::coord_t'(int'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
  endfunction

  // unused fields carry random bits
  function automatic stim_t blank_row();
    stim_t st;
    st.cmd = chc_pkg::cmd_t'($urandom_range(0, 1));
    st.idx = IDX_W'($urandom);
    for (int c = 0; c < 3; c++) begin
      st.pos[c] = rand_coord();
      st.vel[c] = rand_coord();
    end
    st.t     = PARAM_W'($urandom);
    st.known = 1'b0;
    st.want  = '{x: '0, y: '0, z: '0, clamped: 1'b0};
    return st;
  endfunction

  function automatic stim_t knot_row(int idx, chc_pkg::coord_t px, chc_pkg::coord_t py,
                                     chc_pkg::coord_t pz, chc_pkg::coord_t vx,
                                     chc_pkg::coord_t vy, chc_pkg::coord_t vz);
    stim_t st;
    st     = blank_row();
    st.cmd = chc_pkg::CMD_WRITE;
    st.idx = IDX_W'(idx);
    st.pos = '{px, py, pz};
    st.vel = '{vx, vy, vz};
    return st;
  endfunction

  function automatic stim_t eval_row(int t);
    stim_t st;
    st     = blank_row();
    st.cmd = chc_pkg::CMD_EVAL;
    st.t   = PARAM_W'(t);
    return st;
  endfunction

  function automatic stim_t eval_row_known(int t, chc_pkg::coord_t x, chc_pkg::coord_t y,
                                           chc_pkg::coord_t z, logic cl);
    stim_t st;
    st       = eval_row(t);
    st.known = 1'b1;
    st.want  = '{x: x, y: y, z: z, clamped: cl};
    return st;
  endfunction

  // mostly well-formed: knots in use, parameters on the curve
  function automatic stim_t random_stim();
    stim_t st;
    int p, r;
    st = blank_row();
    p  = eff_pieces();
    r  = $urandom_range(0, 99);
    if (r < 30) begin
      st.cmd = chc_pkg::CMD_WRITE;
      r = $urandom_range(0, 99);
      if (r < 85) st.idx = IDX_W'($urandom_range(0, p));
      else if (r < 93) st.idx = IDX_W'($urandom_range(0, MAX_PIECES));
      else st.idx = IDX_W'($urandom_range(MAX_PIECES + 1, 31));
    end else begin
      st.cmd = chc_pkg::CMD_EVAL;
      r = $urandom_range(0, 99);
      if (r < 70) st.t = PARAM_W'($urandom_range(0, p << FRAC_BITS));
      else if (r < 82) st.t = PARAM_W'($urandom_range(0, p) << FRAC_BITS);
      else if (r < 92) st.t = PARAM_W'((p << FRAC_BITS) + $urandom_range(1, 4096));
      else st.t = PARAM_W'($urandom);
    end
    return st;
  endfunction

  // one input transfer; the predictor follows at the accepting edge
  task automatic push_item(input stim_t st);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= st.cmd;
    in_knot_index <= st.idx;
    in_knot_pos_x <= st.pos[0];
    in_knot_pos_y <= st.pos[1];
    in_knot_pos_z <= st.pos[2];
    in_knot_vel_x <= st.vel[0];
    in_knot_vel_y <= st.vel[1];
    in_knot_vel_z <= st.vel[2];
    in_eval_param <= st.t;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (st.cmd == chc_pkg::CMD_WRITE) begin
      // indexes past the table are dropped
      if (st.idx <= MAX_PIECES) begin
        knot_pos_tbl[st.idx] = st.pos;
        knot_vel_tbl[st.idx] = st.vel;
      end
    end else begin
      pending_points.push_back(st.known ? st.want : hermite_point(st.t));
    end
  endtask

  // setup and access cycle; leaves the bus selected for a following transfer
  task automatic apb_access(input bit wr, input int reg_idx,
                            input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_AW'(reg_idx * 4);
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
  endtask

  task automatic set_register(input int reg_idx, input int value);
    logic [CFG_DW-1:0] rd;
    apb_access(1'b1, reg_idx, ($urandom & ~32'h1F) | CFG_DW'(value), rd);
    // a new piece count also wipes the knot table
    if (reg_idx == REG_PIECES_I) begin
      pieces_reg = PIECES_W'(value);
      clear_knots();
    end
    apb_access(1'b0, REG_PIECES_I, '0, rd);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (rd !== CFG_DW'(pieces_reg)) begin
      $error("pieces_in_use: expected %0d, got %0d", pieces_reg, rd);
      fail_count++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls plus the long hold-off on request
  initial begin : result_stall
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_served != holds_requested) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap(recv_quiet);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    curve_point_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_points.size() == 0) begin
        $error("result transfer with no evaluate pending");
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, out_point_x);
          fail_count++;
        end
        if (out_point_y !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, out_point_y);
          fail_count++;
        end
        if (out_point_z !== want.z) begin
          $error("point_z: expected %0d, got %0d", want.z, out_point_z);
          fail_count++;
        end
        if (out_param_clamped !== want.clamped) begin
          $error("param_clamped: expected %0b, got %0b", want.clamped, out_param_clamped);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** cubic_hermite_curve_eval: FAILED **");
      $finish;
    end
  end

  initial begin : main_seq
    stim_t directed[$];
    stim_t st;
    int val, reg_idx, sent;
    bit squeeze;
    fail_count      = 0;
    cycle_count     = 0;
    send_quiet      = 1'b0;
    recv_quiet      = 1'b0;
    holds_requested = 0;
    holds_served    = 0;
    pieces_reg      = PIECES_W'(1);
    clear_knots();

    rst_n         <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    in_valid      <= 1'b0;
    in_command    <= chc_pkg::CMD_WRITE;
    in_knot_index <= '0;
    in_knot_pos_x <= '0;
    in_knot_pos_y <= '0;
    in_knot_pos_z <= '0;
    in_knot_vel_x <= '0;
    in_knot_vel_y <= '0;
    in_knot_vel_z <= '0;
    in_eval_param <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, one piece in use after reset
    directed.push_back(eval_row_known(0, '0, '0, '0, 1'b0));
    directed.push_back(eval_row_known(21'h1F_FFFF, '0, '0, '0, 1'b1));
    directed.push_back(knot_row(0, COORD_MAX, COORD_MIN, ONE_Q, COORD_MIN, COORD_MAX, MINUS_1));
    directed.push_back(knot_row(1, COORD_MIN, COORD_MAX, MINUS_1, COORD_MAX, COORD_MIN, '0));
    directed.push_back(eval_row_known(0, COORD_MAX, COORD_MIN, ONE_Q, 1'b0));
    // parameter at the end, then just past it
    directed.push_back(eval_row_known(32'h1_0000, COORD_MIN, COORD_MAX, MINUS_1, 1'b0));
    directed.push_back(eval_row_known(32'h1_0001, COORD_MIN, COORD_MAX, MINUS_1, 1'b1));
    directed.push_back(eval_row(32'h8000));
    directed.push_back(eval_row(1));
    directed.push_back(eval_row(32'hFFFF));
    // out-of-table indexes are dropped, knot 16 is kept but unused
    directed.push_back(knot_row(MAX_PIECES + 1, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q));
    directed.push_back(knot_row(31, MINUS_1, MINUS_1, MINUS_1, MINUS_1, MINUS_1, MINUS_1));
    directed.push_back(knot_row(MAX_PIECES, ONE_Q, MINUS_1, ONE_Q, MINUS_1, ONE_Q, MINUS_1));
    directed.push_back(eval_row(32'h4000));
    // tangents that push the blend past both rails
    directed.push_back(knot_row(0, COORD_MAX, COORD_MIN, '0, COORD_MAX, COORD_MIN, '0));
    directed.push_back(knot_row(1, COORD_MAX, COORD_MIN, '0, COORD_MIN, COORD_MAX, '0));
    directed.push_back(eval_row(32'h8000));
    directed.push_back(eval_row(32'h2AAA));
    directed.push_back(eval_row_known(32'h1_0000, COORD_MAX, COORD_MIN, '0, 1'b0));
    directed.push_back(eval_row_known(21'h1F_FFFF, COORD_MAX, COORD_MIN, '0, 1'b1));
    directed.push_back(knot_row(0, MINUS_1, ONE_Q, '0, ONE_Q, MINUS_1, ONE_Q));
    directed.push_back(eval_row(32'hC000));
    foreach (directed[i]) push_item(directed[i]);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      reg_idx    = REG_PIECES_I;
      squeeze    = 1'b0;
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      case (ph)
        0: val = MAX_PIECES;
        1: val = 0;
        2: begin
          val        = 31;
          squeeze    = 1'b1;
          send_quiet = 1'b1;
        end
        // write to an unmapped register: table and piece count stay
        3: begin
          reg_idx = REG_SPARE;
          val     = 5;
        end
        4: begin
          val        = 1;
          send_quiet = 1'b1;
          recv_quiet = 1'b1;
        end
        5: val = MAX_PIECES + 1;
        6: val = 2;
        default: val = $urandom_range(0, 31);
      endcase
      set_register(reg_idx, val);
      if (squeeze) holds_requested++;
      sent = 0;
      if (reg_idx == REG_PIECES_I) begin
        for (int k = 0; k <= eff_pieces(); k++) begin
          st     = blank_row();
          st.cmd = chc_pkg::CMD_WRITE;
          st.idx = IDX_W'(k);
          push_item(st);
          sent++;
        end
      end
      while (sent < ITEMS_PER_PHASE) begin
        push_item(random_stim());
        sent++;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("** cubic_hermite_curve_eval: PASSED **");
    end else begin
      $display("** cubic_hermite_curve_eval: FAILED **");
    end
    $finish;
  end

endmodule
